// ===== hw/rtl/mi3_pkg.sv =====
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 fixed-point matrix inverse: default element
// format, tolerance register format and the cofactor index table.
// ---------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int N_ELEM    = 9;
  localparam int TOL_WIDTH = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

  // adj[i] = m[a]*m[b] - m[c]*m[d], row-major element indices
  localparam int COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

// ===== hw/rtl/mi3_cofactor.sv =====
// ---------------------------------------------------------------------------
// mi3_cofactor
// One adjugate lane: a*b - c*d over two pipeline stages, exact width.
// ---------------------------------------------------------------------------
module mi3_cofactor #(
  parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [ELEMENT_WIDTH-1:0] a,
  input  logic signed [ELEMENT_WIDTH-1:0] b,
  input  logic signed [ELEMENT_WIDTH-1:0] c,
  input  logic signed [ELEMENT_WIDTH-1:0] d,
  output logic signed [2*ELEMENT_WIDTH:0] adj
);
  import mi3_pkg::*;

  localparam int W  = ELEMENT_WIDTH;
  localparam int AW = 2*W+1;

  logic signed [2*W-1:0] prod_ab;
  logic signed [2*W-1:0] prod_cd;

  // form both products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_ab <= a * b;
      prod_cd <= c * d;
    end
  end

  // take the difference
  always_ff @(posedge clk) begin
    if (en) begin
      adj <= AW'(prod_ab) - AW'(prod_cd);
    end
  end

endmodule

// ===== hw/rtl/mi3_det.sv =====
// ---------------------------------------------------------------------------
// mi3_det
// Merge stage: determinant from the first row and its cofactors, magnitude,
// sign and the singular decision against the tolerance.
// ---------------------------------------------------------------------------
module mi3_det #(
  parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ELEMENT_WIDTH-1:0]  m0,
  input  logic signed [ELEMENT_WIDTH-1:0]  m1,
  input  logic signed [ELEMENT_WIDTH-1:0]  m2,
  input  logic signed [2*ELEMENT_WIDTH:0]  a0,
  input  logic signed [2*ELEMENT_WIDTH:0]  a3,
  input  logic signed [2*ELEMENT_WIDTH:0]  a6,
  input  logic [mi3_pkg::TOL_WIDTH-1:0]    tol,
  output logic [3*ELEMENT_WIDTH+2:0]       absd,
  output logic                             det_neg,
  output logic                             singular
);
  import mi3_pkg::*;

  localparam int W    = ELEMENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int DETW = 3*W+3;
  localparam int TSW  = TOL_WIDTH + 2*F;
  localparam int CMPW = (DETW > TSW) ? DETW : TSW;

  logic signed [W:0]   lo0, lo1, lo2;
  logic signed [2*W:0] pl0, pl1, pl2, ph0, ph1, ph2;
  logic signed [DETW-1:0] det;
  logic signed [DETW-1:0] det_sum;
  logic [DETW-1:0]     mag;
  logic [CMPW-1:0]     tol_sh;

  assign lo0 = {1'b0, a0[W-1:0]};
  assign lo1 = {1'b0, a3[W-1:0]};
  assign lo2 = {1'b0, a6[W-1:0]};

  // split each cofactor into low and high halves, multiply
  always_ff @(posedge clk) begin
    if (en) begin
      pl0 <= m0 * lo0;
      pl1 <= m1 * lo1;
      pl2 <= m2 * lo2;
      ph0 <= m0 * $signed(a0[2*W:W]);
      ph1 <= m1 * $signed(a3[2*W:W]);
      ph2 <= m2 * $signed(a6[2*W:W]);
    end
  end

  assign det_sum = (DETW'(ph0) <<< W) + DETW'(pl0)
                 + (DETW'(ph1) <<< W) + DETW'(pl1)
                 + (DETW'(ph2) <<< W) + DETW'(pl2);

  // accumulate the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      det <= det_sum;
    end
  end

  assign mag    = det[DETW-1] ? DETW'(-det) : DETW'(det);
  assign tol_sh = CMPW'(tol) << (2*F);

  // judge singularity
  always_ff @(posedge clk) begin
    if (en) begin
      absd     <= mag;
      det_neg  <= det[DETW-1];
      singular <= (det == '0) || (CMPW'(mag) < tol_sh);
    end
  end

endmodule

// ===== hw/rtl/mi3_div_lane.sv =====
// ---------------------------------------------------------------------------
// mi3_div_lane
// One output lane: rounded quotient adj*2^(2F)/det by a restoring divider,
// one quotient bit per stage, then saturation and sign.
// ---------------------------------------------------------------------------
module mi3_div_lane #(
  parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [2*ELEMENT_WIDTH:0] adj,
  input  logic [3*ELEMENT_WIDTH+2:0]      absd,
  input  logic                            det_neg,
  output logic [ELEMENT_WIDTH-1:0]        q_out
);
  import mi3_pkg::*;

  localparam int W    = ELEMENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int AW   = 2*W+1;
  localparam int DETW = 3*W+3;
  localparam int QB   = W+1;
  localparam int NW0  = (AW+2*F+1 > DETW) ? AW+2*F+1 : DETW;
  localparam int NW   = NW0 + 1;
  localparam int DNW  = DETW + 1;
  localparam int CW   = (NW > DNW+QB) ? NW : DNW+QB;
  localparam int RW   = (NW > DNW+1) ? NW : DNW+1;

  logic [AW-1:0]  aabs;
  logic [NW-1:0]  num;
  logic [NW-1:0]  num_sh;
  logic [DNW-1:0] den_in;

  logic [RW-1:0]  rem   [0:QB];
  logic [DNW-1:0] den   [0:QB];
  logic [QB-1:0]  quo   [0:QB];
  logic [QB-1:0]  nlow  [0:QB];
  logic           ovf   [0:QB];
  logic           neg   [0:QB];

  assign aabs   = adj[AW-1] ? AW'(-adj) : AW'(adj);
  assign num    = (NW'(aabs) << (2*F+1)) + NW'(absd);
  assign num_sh = num >> QB;
  assign den_in = {absd, 1'b0};

  // set up numerator, divisor and overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(num_sh);
      den[0]  <= den_in;
      quo[0]  <= '0;
      nlow[0] <= num[QB-1:0];
      ovf[0]  <= CW'(num) >= (CW'(den_in) << QB);
      neg[0]  <= adj[AW-1] ^ det_neg;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [RW-1:0] trial;
    logic          take;
    assign trial = {rem[i][RW-2:0], nlow[i][QB-1-i]};
    assign take  = trial >= RW'(den[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? (trial - RW'(den[i])) : trial;
        quo[i+1]  <= {quo[i][QB-2:0], take};
        den[i+1]  <= den[i];
        nlow[i+1] <= nlow[i];
        ovf[i+1]  <= ovf[i];
        neg[i+1]  <= neg[i];
      end
    end
  end

  logic [QB-1:0] lim;
  logic [QB-1:0] qsat;
  logic [QB-1:0] qval;

  assign lim  = (QB'(1) << (W-1)) - QB'(!neg[QB]);
  assign qsat = (ovf[QB] || (quo[QB] > lim)) ? lim : quo[QB];
  assign qval = neg[QB] ? QB'(-qsat) : qsat;

  // clamp and apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      q_out <= qval[W-1:0];
    end
  end

endmodule

// ===== hw/rtl/matrix_inverse_3x3.sv =====
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 fixed-point matrix inverse by the adjugate method.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one row-major 3x3 matrix per transaction, element r0c0 in the
//   lowest ELEMENT_WIDTH bits of s_tdata. m_* returns the nine inverse
//   elements, or the input matrix if singular, in the same layout and the
//   singular flag in m_tuser. cfg_* writes the singular tolerance (Q format,
//   |det| below it means singular); write it only while the block is idle.
//   Throughput: one matrix per cycle while the skid register is empty;
//   every stage advances together. Pipeline: nine cofactor lanes
//   (2 stages), the determinant merge (3 stages) and nine restoring
//   dividers that resolve one quotient bit per stage (ELEMENT_WIDTH+3
//   stages).
//   Stall: an output register plus one skid register hold results; the
//   pipeline freezes only while the skid register is full, so input is
//   still taken while one result waits.
//   Reset: pipeline empties, tolerance returns to 1.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
  parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mi3_pkg::TOL_WIDTH-1:0]          cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // in_r0c0, in_r0c1, ... in_r2c2, zero pad
  input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // out_r0c0, out_r0c1, ... out_r2c2, zero pad
  output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]   m_tdata,
  // singular
  output logic [0:0]                             m_tuser
);
  import mi3_pkg::*;

  localparam int W    = ELEMENT_WIDTH;
  localparam int AW   = 2*W+1;
  localparam int DETW = 3*W+3;
  localparam int DW   = ((9*W+7)/8)*8;
  localparam int LD   = W+3;
  localparam int LAT  = 5 + LD;

  logic en;
  logic [LAT:0] vld;
  logic [N_ELEM-1:0][W-1:0] mat_dly [0:LAT];

  logic tol_unused;
  logic [TOL_WIDTH-1:0] tol;

  // tolerance register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end
  assign tol_unused = 1'b0;

  assign s_tready = en;

  // valid tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:0], s_tvalid};
    end
  end

  // matrix delay line, kept for the singular echo and the determinant row
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_ELEM; i++) begin
        mat_dly[0][i] <= s_tdata[W*i +: W];
      end
      for (int k = 1; k <= LAT; k++) begin
        mat_dly[k] <= mat_dly[k-1];
      end
    end
  end

  // cofactor lanes
  logic signed [AW-1:0] adj [0:N_ELEM-1];
  for (genvar i = 0; i < N_ELEM; i++) begin : g_cof
    mi3_cofactor #(.ELEMENT_WIDTH(W)) u_cof (
      .clk (clk),
      .en  (en),
      .a   ($signed(mat_dly[0][COF_IDX[i][0]])),
      .b   ($signed(mat_dly[0][COF_IDX[i][1]])),
      .c   ($signed(mat_dly[0][COF_IDX[i][2]])),
      .d   ($signed(mat_dly[0][COF_IDX[i][3]])),
      .adj (adj[i])
    );
  end

  // determinant merge
  logic [DETW-1:0] absd;
  logic            det_neg;
  logic            singular;
  mi3_det #(.ELEMENT_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_det (
    .clk      (clk),
    .en       (en),
    .m0       ($signed(mat_dly[2][0])),
    .m1       ($signed(mat_dly[2][1])),
    .m2       ($signed(mat_dly[2][2])),
    .a0       (adj[0]),
    .a3       (adj[3]),
    .a6       (adj[6]),
    .tol      (tol),
    .absd     (absd),
    .det_neg  (det_neg),
    .singular (singular)
  );

  // align cofactors with the determinant
  logic signed [AW-1:0] adj_dly [0:2][0:N_ELEM-1];
  always_ff @(posedge clk) begin
    if (en) begin
      adj_dly[0] <= adj;
      adj_dly[1] <= adj_dly[0];
      adj_dly[2] <= adj_dly[1];
    end
  end

  // divider lanes
  logic [W-1:0] q [0:N_ELEM-1];
  for (genvar i = 0; i < N_ELEM; i++) begin : g_div
    mi3_div_lane #(.ELEMENT_WIDTH(W), .FRACTION_BITS(FRACTION_BITS)) u_div (
      .clk     (clk),
      .en      (en),
      .adj     (adj_dly[2][i]),
      .absd    (absd),
      .det_neg (det_neg),
      .q_out   (q[i])
    );
  end

  // carry the singular flag alongside the dividers
  logic [LD-1:0] sing_sr;
  always_ff @(posedge clk) begin
    if (en) begin
      sing_sr <= {sing_sr[LD-2:0], singular};
    end
  end

  // select result
  logic [DW-1:0] res_data;
  logic          res_sing;
  assign res_sing = sing_sr[LD-1] | tol_unused;
  always_comb begin
    res_data = '0;
    for (int i = 0; i < N_ELEM; i++) begin
      res_data[W*i +: W] = res_sing ? mat_dly[LAT][i] : q[i];
    end
  end

  // output register with skid
  logic          skid_vld;
  logic [DW-1:0] skid_data;
  logic          skid_sing;
  logic          push;

  assign en   = ~skid_vld;
  assign push = en & vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_vld) begin
        m_tvalid <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_vld) begin
        m_tdata <= skid_data;
        m_tuser <= skid_sing;
      end else begin
        m_tdata <= res_data;
        m_tuser <= res_sing;
      end
    end else if (push) begin
      skid_data <= res_data;
      skid_sing <= res_sing;
    end
  end

endmodule

// ===== test/tb_matrix_inverse_3x3.sv =====
// ---------------------------------------------------------------------------
// tb_matrix_inverse_3x3
// Self-checking bench for the 3x3 fixed-point matrix inverse. Directed and
// random matrices stream through s_*, results on m_* are checked against an
// exact big-integer predictor; tolerance is changed between phases.
// ---------------------------------------------------------------------------
module tb_matrix_inverse_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = mi3_pkg::ELEMENT_WIDTH_DEF;
  localparam int FB = mi3_pkg::FRACTION_BITS_DEF;
  localparam int DW = ((9*EW+7)/8)*8;
  localparam int TW = mi3_pkg::TOL_WIDTH;
  localparam int LATENCY = EW + 9;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [EW-1:0] elem_t;
  typedef struct packed {
    logic   singular;
    elem_t [8:0] m;
  } inverse_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [TW-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [DW-1:0] m_tdata;
  logic [0:0] m_tuser;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial forever #5 clk = ~clk;

  logic [TW-1:0] tolerance = mi3_pkg::TOL_RESET;
  elem_t    pending_matrices[$];
  inverse_t expected_inverses[$];
  int       error_count = 0;
  int       sent_count = 0;
  int       idle_cycles = 0;
  bit       hold_receiver = 0;
  bit       sender_paused = 0;

  // Exact inverse by adjugate; 256-bit signed math covers every product.
  function automatic inverse_t predict_inverse(elem_t m[9], logic [TW-1:0] tol);
    logic signed [255:0] w[9];
    logic signed [255:0] adj[9];
    logic signed [255:0] det, absd, num, q, lim;
    logic [255:0] thr;
    inverse_t r;
    bit neg;
    for (int i = 0; i < 9; i++) w[i] = m[i];
    for (int i = 0; i < 9; i++)
      adj[i] = w[mi3_pkg::COF_IDX[i][0]] * w[mi3_pkg::COF_IDX[i][1]]
             - w[mi3_pkg::COF_IDX[i][2]] * w[mi3_pkg::COF_IDX[i][3]];
    det = w[0]*adj[0] + w[1]*adj[3] + w[2]*adj[6];
    absd = det < 0 ? -det : det;
    thr = 256'(tol) << (2*FB);
    if (absd == 0 || absd < $signed(thr)) begin
      for (int i = 0; i < 9; i++) r.m[i] = m[i];
      r.singular = 1;
      return r;
    end
    for (int i = 0; i < 9; i++) begin
      neg = (adj[i] < 0) ^ (det < 0);
      num = adj[i] < 0 ? -adj[i] : adj[i];
      // round half away from zero: (2|A|<<2F + |D|) / 2|D|
      q = ((num <<< (2*FB+1)) + absd) / (absd <<< 1);
      lim = (256'sd1 <<< (EW-1)) - (neg ? 0 : 1);
      if (q > lim) q = lim;
      r.m[i] = neg ? elem_t'(-q) : elem_t'(q);
    end
    r.singular = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [EW-1:0] got, logic [EW-1:0] exp);
    $display("mismatch %s[%0d]: got %h expected %h", what, idx, got, exp);
    error_count++;
  endtask

  // Driver: present queued matrices with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) sent_count++;
      if (s_tvalid && !s_tready) begin
        // hold the current transaction
      end else if (send_gap > 0 || sender_paused) begin
        if (send_gap > 0) send_gap--;
        s_tvalid <= 0;
      end else if (pending_matrices.size() >= 9) begin
        elem_t m[9];
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) begin
          m[i] = pending_matrices.pop_front();
          d[i*EW +: EW] = m[i];
        end
        expected_inverses.push_back(predict_inverse(m, tolerance));
        s_tdata <= d;
        s_tvalid <= 1;
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // Monitor: random backpressure and field-by-field compare.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        if (expected_inverses.size() == 0) begin
          report_mismatch("unexpected", 0, m_tdata[EW-1:0], '0);
        end else begin
          inverse_t e;
          e = expected_inverses.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[i*EW +: EW] !== e.m[i])
              report_mismatch("element", i, m_tdata[i*EW +: EW], e.m[i]);
          if (m_tuser[0] !== e.singular)
            report_mismatch("singular", 0, EW'(m_tuser[0]), EW'(e.singular));
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end else if (s_tvalid && s_tready) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (hold_receiver) begin
        m_tready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Watchdog on cycles with no transaction.
  always @(posedge clk) begin
    if (!rst && idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_matrix(elem_t m[9]);
    for (int i = 0; i < 9; i++) pending_matrices.push_back(m[i]);
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return elem_t'($urandom);
      1: return $urandom_range(0, 1) ? elem_t'(32'h7fffffff) : elem_t'(32'h80000000);
      2: return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      3: return elem_t'($signed($urandom_range(0, 1 << FB)) - (1 << (FB-1)));
      4: return elem_t'($signed($urandom_range(0, 64)) - 32);
      default: return elem_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic queue_random(int n);
    elem_t m[9];
    int k;
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      k = $urandom_range(0, 7);
      // make some rows dependent or the matrix nearly diagonal
      if (k == 0) for (int c = 0; c < 3; c++) m[6+c] = m[c];
      if (k == 1) for (int i = 0; i < 9; i++)
        m[i] = (i % 4 == 0) ? elem_t'($urandom_range(1, 8) << FB) : elem_t'($urandom_range(0, 255));
      queue_matrix(m);
    end
  endtask

  task automatic wait_drained();
    while (pending_matrices.size() != 0 || s_tvalid || expected_inverses.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TW-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    tolerance = v;
  endtask

  initial begin
    elem_t m[9];
    logic [TW-1:0] tol_set[5];
    tol_set = '{TW'(0), TW'(32'h7fffffff), TW'(1 << FB), TW'(1), TW'(12345)};
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: identity, scaled, zero, extremes, singular rows, overflow.
    m = '{elem_t'(1<<FB),0,0, 0,elem_t'(1<<FB),0, 0,0,elem_t'(1<<FB)}; queue_matrix(m);
    m = '{elem_t'(2<<FB),0,0, 0,elem_t'(-4<<FB),0, 0,0,elem_t'(1<<(FB-1))}; queue_matrix(m);
    m = '{default: 0}; queue_matrix(m);
    m = '{default: elem_t'(32'h7fffffff)}; queue_matrix(m);
    m = '{default: elem_t'(32'h80000000)}; queue_matrix(m);
    m = '{elem_t'(32'h80000000),0,0, 0,elem_t'(32'h7fffffff),0, 0,0,elem_t'(32'h80000000)};
    queue_matrix(m);
    m = '{1,0,0, 0,1,0, 0,0,1}; queue_matrix(m);  // tiny det, flagged singular
    m = '{-1,0,0, 0,1,0, 0,0,1}; queue_matrix(m);
    m = '{elem_t'(1<<FB),elem_t'(2<<FB),elem_t'(3<<FB), elem_t'(4<<FB),elem_t'(5<<FB),
          elem_t'(6<<FB), elem_t'(7<<FB),elem_t'(8<<FB),elem_t'(9<<FB)}; queue_matrix(m);
    m = '{elem_t'(3<<FB),1,2, 5,elem_t'(-7<<FB),11, 13,17,elem_t'(3<<FB)}; queue_matrix(m);
    m = '{elem_t'(32'hffffffff),elem_t'(32'h55555555),elem_t'(32'haaaaaaaa),
          elem_t'(32'h0f0f0f0f),elem_t'(32'hf0f0f0f0),elem_t'(32'h00ff00ff),
          elem_t'(32'h12345678),elem_t'(32'h87654321),elem_t'(32'h3c3c3c3c)};
    queue_matrix(m);
    wait_drained();

    // Phases across tolerance settings; extremes included.
    foreach (tol_set[p]) begin
      write_tolerance(tol_set[p]);
      if (p == 1) begin
        // sender keeps offering while the receiver holds off
        hold_receiver = 1;
        queue_random(60);
        repeat (300) @(posedge clk);
        hold_receiver = 0;
      end else begin
        queue_random(82);
      end
      if (p == 2) begin
        while (pending_matrices.size() > 30*9) @(posedge clk);
        // pause the sender until every result is back
        sender_paused = 1;
        while (expected_inverses.size() != 0) @(posedge clk);
        sender_paused = 0;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
